// ===== design/center_window_color_blob_detector_defines.svh =====
// Assertion macros for the center-window color blob detector.
// Included by the top level; expects clk and rst_n in scope.
`ifndef CENTER_WINDOW_COLOR_BLOB_DETECTOR_DEFINES_SVH
`define CENTER_WINDOW_COLOR_BLOB_DETECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define CWCB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define CWCB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/cwcb_pkg.sv =====
// Shared types, codes and constants for the center-window color blob detector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cwcb_pkg;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 3;
    localparam int LEVEL_W = 8;
    localparam int SUM_W   = 25;
    localparam int SPEED_W = 7;
    localparam int DRIVE_W = 8;
    localparam int DIV_W   = 14;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CRUISE_SPEED   = 3'd2;
    localparam logic [IDX_W-1:0] REG_HOLD_THRESHOLD = 3'd3;
    localparam logic [IDX_W-1:0] REG_PAUSE_RELOAD   = 3'd4;

    // Register reset values
    localparam int RST_FRAME_WIDTH    = 64;
    localparam int RST_FRAME_HEIGHT   = 64;
    localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED = 7'd6;
    localparam logic [CFG_W-1:0] RST_HOLD_THRESHOLD = 11'd10;
    localparam logic [CFG_W-1:0] RST_PAUSE_RELOAD   = 11'd20;

    // Blob color codes
    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;
    localparam logic [1:0] COLOR_NONE  = 2'd3;

    typedef enum logic [1:0] {
        OP_PIXEL      = 2'd0,
        OP_STEP_IMAGE = 2'd1,
        OP_STEP_BLIND = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left_drive;
        logic signed [DRIVE_W-1:0] right_drive;
        logic [1:0]                blob_color;
        logic                      blob_found;
    } out_item_t;

    // Steering settings used at each control step
    typedef struct packed {
        logic [SPEED_W-1:0] cruise_speed;
        logic [CFG_W-1:0]   hold_threshold;
        logic [CFG_W-1:0]   pause_reload;
    } steer_cfg_t;

    // Floor of x/3 by reciprocal multiply, exact for x below 2^17
    function automatic logic [DIV_W-1:0] div3(input logic [DIV_W-1:0] x);
        logic [DIV_W+16:0] prod;
        prod = {17'd0, x} * {{(DIV_W+1){1'b0}}, 16'hAAAB};
        return prod[DIV_W+16:17];
    endfunction

endpackage

// ===== design/cwcb_cfg.sv =====
// Configuration registers and the window bounds derived from them.
// Depends on cwcb_pkg.
`timescale 1ns / 1ps

module cwcb_cfg #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cwcb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cwcb_pkg::CFG_W-1:0]    cfg_data,
    output logic [WW-1:0]                 width_lim,
    output logic [WW-1:0]                 col_lo,
    output logic [WW-1:0]                 col_hi,
    output logic [HW-1:0]                 height_lim,
    output logic [HW-1:0]                 row_lo,
    output logic [HW-1:0]                 row_hi,
    output cwcb_pkg::steer_cfg_t          steer
);

    localparam int W_RST = (cwcb_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : cwcb_pkg::RST_FRAME_WIDTH;
    localparam int H_RST = (cwcb_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : cwcb_pkg::RST_FRAME_HEIGHT;
    localparam int DW = cwcb_pkg::DIV_W;

    logic [WW-1:0] width_lim_reg, col_lo_reg, col_hi_reg;
    logic [HW-1:0] height_lim_reg, row_lo_reg, row_hi_reg;
    cwcb_pkg::steer_cfg_t steer_reg;

    logic [WW-1:0] width_clamp;
    logic [HW-1:0] height_clamp;
    logic [DW-1:0] width_ext, height_ext, height_x3;

    // Clamp the frame size to what the counters can hold
    always_comb
    begin
        if (int'(cfg_data) > MAX_WIDTH)
            width_clamp = WW'(MAX_WIDTH);
        else
            width_clamp = WW'(cfg_data);
        if (int'(cfg_data) > MAX_HEIGHT)
            height_clamp = HW'(MAX_HEIGHT);
        else
            height_clamp = HW'(cfg_data);
        width_ext  = DW'(width_clamp);
        height_ext = DW'(height_clamp);
        height_x3  = (height_ext << 1) + height_ext;
    end

    // Decode writes and store derived bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_lim_reg  <= WW'(W_RST);
            col_lo_reg     <= WW'(W_RST / 3);
            col_hi_reg     <= WW'((2 * W_RST) / 3);
            height_lim_reg <= HW'(H_RST);
            row_lo_reg     <= HW'(H_RST / 2);
            row_hi_reg     <= HW'((3 * H_RST) / 4);
            steer_reg.cruise_speed   <= cwcb_pkg::RST_CRUISE_SPEED;
            steer_reg.hold_threshold <= cwcb_pkg::RST_HOLD_THRESHOLD;
            steer_reg.pause_reload   <= cwcb_pkg::RST_PAUSE_RELOAD;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                cwcb_pkg::REG_FRAME_WIDTH:
                begin
                    width_lim_reg <= width_clamp;
                    col_lo_reg    <= WW'(cwcb_pkg::div3(width_ext));
                    col_hi_reg    <= WW'(cwcb_pkg::div3(width_ext << 1));
                end
                cwcb_pkg::REG_FRAME_HEIGHT:
                begin
                    height_lim_reg <= height_clamp;
                    row_lo_reg     <= HW'(height_ext >> 1);
                    row_hi_reg     <= HW'(height_x3 >> 2);
                end
                cwcb_pkg::REG_CRUISE_SPEED:
                    steer_reg.cruise_speed <= cfg_data[cwcb_pkg::SPEED_W-1:0];
                cwcb_pkg::REG_HOLD_THRESHOLD:
                    steer_reg.hold_threshold <= cfg_data;
                cwcb_pkg::REG_PAUSE_RELOAD:
                    steer_reg.pause_reload <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign width_lim  = width_lim_reg;
    assign col_lo     = col_lo_reg;
    assign col_hi     = col_hi_reg;
    assign height_lim = height_lim_reg;
    assign row_lo     = row_lo_reg;
    assign row_hi     = row_hi_reg;
    assign steer      = steer_reg;

endmodule

// ===== design/cwcb_accum.sv =====
// Raster position tracking and saturating color sums over the center window.
// Depends on cwcb_pkg.
`timescale 1ns / 1ps

module cwcb_accum #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_en,
    input  logic                          clear,
    input  cwcb_pkg::in_item_t            pixel,
    input  logic [WW-1:0]                 width_lim,
    input  logic [WW-1:0]                 col_lo,
    input  logic [WW-1:0]                 col_hi,
    input  logic [HW-1:0]                 height_lim,
    input  logic [HW-1:0]                 row_lo,
    input  logic [HW-1:0]                 row_hi,
    output logic [cwcb_pkg::SUM_W-1:0]    sum_red,
    output logic [cwcb_pkg::SUM_W-1:0]    sum_green,
    output logic [cwcb_pkg::SUM_W-1:0]    sum_blue
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int SW = cwcb_pkg::SUM_W;

    logic [CW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [SW-1:0] sum_red_reg, sum_red_next;
    logic [SW-1:0] sum_green_reg, sum_green_next;
    logic [SW-1:0] sum_blue_reg, sum_blue_next;

    logic          in_frame, in_window;
    logic [WW:0]   col_ext, col_inc;
    logic [SW:0]   add_red, add_green, add_blue;

    // Window test and raster advance
    always_comb
    begin
        col_ext   = (WW + 1)'(col_reg);
        col_inc   = col_ext + 1'b1;
        in_frame  = row_reg < height_lim;
        in_window = (col_ext >= {1'b0, col_lo}) && (col_ext < {1'b0, col_hi}) &&
                    (row_reg >= row_lo) && (row_reg < row_hi);
        add_red   = {1'b0, sum_red_reg} + (SW + 1)'(pixel.red_level);
        add_green = {1'b0, sum_green_reg} + (SW + 1)'(pixel.green_level);
        add_blue  = {1'b0, sum_blue_reg} + (SW + 1)'(pixel.blue_level);

        col_next       = col_reg;
        row_next       = row_reg;
        sum_red_next   = sum_red_reg;
        sum_green_next = sum_green_reg;
        sum_blue_next  = sum_blue_reg;

        if (clear)
        begin
            col_next       = '0;
            row_next       = '0;
            sum_red_next   = '0;
            sum_green_next = '0;
            sum_blue_next  = '0;
        end
        else if (pixel_en && in_frame)
        begin
            // Saturate each sum at its all-ones value
            if (in_window)
            begin
                sum_red_next   = add_red[SW] ? '1 : add_red[SW-1:0];
                sum_green_next = add_green[SW] ? '1 : add_green[SW-1:0];
                sum_blue_next  = add_blue[SW] ? '1 : add_blue[SW-1:0];
            end
            if (col_inc >= {1'b0, width_lim})
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            sum_red_reg   <= sum_red_next;
            sum_green_reg <= sum_green_next;
            sum_blue_reg  <= sum_blue_next;
        end
    end

    assign sum_red   = sum_red_reg;
    assign sum_green = sum_green_reg;
    assign sum_blue  = sum_blue_reg;

endmodule

// ===== design/cwcb_ctrl.sv =====
// Pause counter and wheel command decision at each control step.
// Depends on cwcb_pkg.
`timescale 1ns / 1ps

module cwcb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic                          has_image,
    input  logic [cwcb_pkg::SUM_W-1:0]    sum_red,
    input  logic [cwcb_pkg::SUM_W-1:0]    sum_green,
    input  logic [cwcb_pkg::SUM_W-1:0]    sum_blue,
    input  cwcb_pkg::steer_cfg_t          steer,
    output cwcb_pkg::out_item_t           result
);

    localparam int SW = cwcb_pkg::SUM_W;
    localparam int TW = SW + 2;
    localparam int DRW = cwcb_pkg::DRIVE_W;

    logic [cwcb_pkg::CFG_W-1:0] pause_reg, pause_next, pause_dec;
    logic [TW-1:0] red_ext, green_ext, blue_ext;
    logic [TW-1:0] red_x3, green_x3, blue_x3;
    logic          red_dom, green_dom, blue_dom;
    logic signed [DRW-1:0] turn_left, turn_right;
    logic [1:0]    color;

    // Dominance tests: a channel above three times each of the others
    always_comb
    begin
        red_ext   = TW'(sum_red);
        green_ext = TW'(sum_green);
        blue_ext  = TW'(sum_blue);
        red_x3    = (red_ext << 1) + red_ext;
        green_x3  = (green_ext << 1) + green_ext;
        blue_x3   = (blue_ext << 1) + blue_ext;
        red_dom   = (red_ext > green_x3) && (red_ext > blue_x3);
        green_dom = (green_ext > red_x3) && (green_ext > blue_x3);
        blue_dom  = (blue_ext > red_x3) && (blue_ext > green_x3);
        if (red_dom)
            color = cwcb_pkg::COLOR_RED;
        else if (green_dom)
            color = cwcb_pkg::COLOR_GREEN;
        else if (blue_dom)
            color = cwcb_pkg::COLOR_BLUE;
        else
            color = cwcb_pkg::COLOR_NONE;
    end

    // Decide wheel commands after the pause decrement
    always_comb
    begin
        pause_dec  = (pause_reg != '0) ? pause_reg - 1'b1 : pause_reg;
        turn_right = $signed({1'b0, steer.cruise_speed});
        turn_left  = -turn_right;

        result.left_drive  = '0;
        result.right_drive = '0;
        result.blob_color  = cwcb_pkg::COLOR_NONE;
        result.blob_found  = 1'b0;
        pause_next         = pause_dec;

        if (pause_dec > steer.hold_threshold)
        begin
            // stand still
        end
        else if (pause_dec != '0)
        begin
            result.left_drive  = turn_left;
            result.right_drive = turn_right;
        end
        else if (!has_image)
        begin
            // no image: stop
        end
        else if (color == cwcb_pkg::COLOR_NONE)
        begin
            result.left_drive  = turn_left;
            result.right_drive = turn_right;
        end
        else
        begin
            result.blob_color = color;
            result.blob_found = 1'b1;
            pause_next        = steer.pause_reload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pause_reg <= '0;
        else if (step_en)
            pause_reg <= pause_next;
    end

endmodule

// ===== design/center_window_color_blob_detector.sv =====
// Top level of the center-window color blob detector: input register,
// result register and handshake. Depends on cwcb_pkg, cwcb_cfg, cwcb_accum,
// cwcb_ctrl and center_window_color_blob_detector_defines.svh.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid / in_stall        in_item  (in_item_t)
//   out      output     out_valid / out_stall      out_item (out_item_t)
//   cfg      input      cfg_wr_en                  cfg_index, cfg_data
//
// One transaction per cycle, except while a marker waits on a full and stalled
// result register; a step result goes through the input register, then the result register.
// Pixel and undefined transactions never wait on the output side; a marker
// waits in the input register only while the result register is full and
// stalled. Reset clears position, sums, pause count and both valid flags;
// no clearing pass is needed.
`timescale 1ns / 1ps

`include "center_window_color_blob_detector_defines.svh"

module center_window_color_blob_detector #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cwcb_pkg::in_item_t            in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cwcb_pkg::out_item_t           out_item,
    input  logic                          cfg_wr_en,
    input  logic [cwcb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [cwcb_pkg::CFG_W-1:0]    cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic                 in_vld_reg;
    cwcb_pkg::in_item_t   in_item_reg;
    logic                 out_vld_reg, out_vld_next;
    cwcb_pkg::out_item_t  out_item_reg;

    logic                 is_pixel, is_marker, has_image, advance;
    logic [WW-1:0]        width_lim, col_lo, col_hi;
    logic [HW-1:0]        height_lim, row_lo, row_hi;
    cwcb_pkg::steer_cfg_t steer;
    logic [cwcb_pkg::SUM_W-1:0] sum_red, sum_green, sum_blue;
    cwcb_pkg::out_item_t  result;
    logic                 found_stopped;

    // Decode the held transaction
    always_comb
    begin
        is_pixel  = 1'b0;
        is_marker = 1'b0;
        has_image = 1'b0;
        unique case (cwcb_pkg::op_t'(in_item_reg.op)) inside
            cwcb_pkg::OP_PIXEL:
                is_pixel = 1'b1;
            cwcb_pkg::OP_STEP_IMAGE, cwcb_pkg::OP_STEP_BLIND:
            begin
                is_marker = 1'b1;
                has_image = (in_item_reg.op == cwcb_pkg::OP_STEP_IMAGE);
            end
            default:
                ;
        endcase
    end

    // Advance unless a marker finds the result register full and stalled
    assign advance  = in_vld_reg && !(is_marker && out_vld_reg && out_stall);
    assign in_stall = in_vld_reg && !advance;

    // Hold or load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_item_reg <= in_item;
    end

    cwcb_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .width_lim  (width_lim),
        .col_lo     (col_lo),
        .col_hi     (col_hi),
        .height_lim (height_lim),
        .row_lo     (row_lo),
        .row_hi     (row_hi),
        .steer      (steer)
    );

    cwcb_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_en   (advance && is_pixel),
        .clear      (advance && is_marker),
        .pixel      (in_item_reg),
        .width_lim  (width_lim),
        .col_lo     (col_lo),
        .col_hi     (col_hi),
        .height_lim (height_lim),
        .row_lo     (row_lo),
        .row_hi     (row_hi),
        .sum_red    (sum_red),
        .sum_green  (sum_green),
        .sum_blue   (sum_blue)
    );

    cwcb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance && is_marker),
        .has_image  (has_image),
        .sum_red    (sum_red),
        .sum_green  (sum_green),
        .sum_blue   (sum_blue),
        .steer      (steer),
        .result     (result)
    );

    // Load a step result or drop the taken one
    always_comb
    begin
        if (advance && is_marker)
            out_vld_next = 1'b1;
        else if (!out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_marker)
            out_item_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_item_reg;

    // A detection stops both wheels and names a color
    assign found_stopped = (out_item_reg.left_drive == 0) && (out_item_reg.right_drive == 0) &&
                           (out_item_reg.blob_color != cwcb_pkg::COLOR_NONE);

    // Checks on result flow and detection commands
    `CWCB_ASSERT_NEXT(a_marker_gives_result, advance && is_marker, out_vld_reg)
    `CWCB_ASSERT_NEXT(a_pixel_no_result, in_vld_reg && !is_marker && !out_vld_reg, !out_vld_reg)
    `CWCB_ASSERT_SAME(a_found_stops, out_vld_reg && out_item_reg.blob_found, found_stopped)

endmodule
